@@ hw/rtl/aabbsb_pkg.sv @@
// ----------------------------------------------------------------------------
// aabbsb_pkg: shared types for the bounding box and sphere block
// Holds the control word that the sequencer hands to each axis lane.
// ----------------------------------------------------------------------------
package aabbsb_pkg;

   // Control word from the sequencer to every axis lane.
   typedef struct packed {
      logic take;          // a vertex word is accepted this cycle
      logic surf_end;      // the accepted vertex closes its surface
      logic surf_started;  // the surface box already holds data
      logic mesh_started;  // the mesh box already holds data
      logic sel_mesh;      // capture the mesh box rather than the surface box
      logic capture;       // register centre and half extent
      logic square;        // register the squared half extent
   } lane_ctrl_type;

endpackage

@@ hw/rtl/aabbsb_lane.sv @@
// ----------------------------------------------------------------------------
// aabbsb_lane: one axis of the bounding box tracker
// Keeps the running minimum and maximum of the surface and of the mesh along
// one axis, and derives centre, half extent and squared half extent on demand.
// ----------------------------------------------------------------------------
module aabbsb_lane
   import aabbsb_pkg::*;
#(
   parameter int CB = 24
) (
   input  logic                 clock,
   input  lane_ctrl_type        ctrl,
   input  logic signed [CB-1:0] pos,
   output logic signed [CB-1:0] centre,
   output logic [CB-2:0]        half,
   output logic [2*CB-3:0]      square
);

   logic signed [CB-1:0] surf_min_ff, surf_max_ff, mesh_min_ff, mesh_max_ff;
   logic signed [CB-1:0] surf_min_in, surf_max_in, mesh_min_in, mesh_max_in;
   logic signed [CB-1:0] lo, hi;
   logic signed [CB:0]   sum_w;
   logic [CB:0]          diff_w;
   logic signed [CB-1:0] centre_ff;
   logic [CB-2:0]        half_ff;
   logic [2*CB-3:0]      square_ff;

   // New surface and mesh bounds; the first vertex or surface seeds each box.
   always_comb begin
      surf_min_in = (!ctrl.surf_started || pos < surf_min_ff) ? pos : surf_min_ff;
      surf_max_in = (!ctrl.surf_started || pos > surf_max_ff) ? pos : surf_max_ff;
      mesh_min_in = (!ctrl.mesh_started || surf_min_in < mesh_min_ff) ?
                    surf_min_in : mesh_min_ff;
      mesh_max_in = (!ctrl.mesh_started || surf_max_in > mesh_max_ff) ?
                    surf_max_in : mesh_max_ff;
   end

   // Tracker registers; the mesh box folds in the surface box at surface end.
   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         surf_min_ff <= surf_min_in;
         surf_max_ff <= surf_max_in;
         if (ctrl.surf_end) begin
            mesh_min_ff <= mesh_min_in;
            mesh_max_ff <= mesh_max_in;
         end
      end
   end

   // Centre is the arithmetic half of the sum, half extent that of the span.
   always_comb begin
      lo     = ctrl.sel_mesh ? mesh_min_ff : surf_min_ff;
      hi     = ctrl.sel_mesh ? mesh_max_ff : surf_max_ff;
      sum_w  = {hi[CB-1], hi} + {lo[CB-1], lo};
      diff_w = {hi[CB-1], hi} - {lo[CB-1], lo};
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         centre_ff <= sum_w[CB:1];
         half_ff   <= diff_w[CB-1:1];
      end
      if (ctrl.square) begin
         square_ff <= (2*CB-2)'(half_ff) * (2*CB-2)'(half_ff);
      end
   end

   assign centre = centre_ff;
   assign half   = half_ff;
   assign square = square_ff;

endmodule

@@ hw/rtl/aabbsb_sqrt.sv @@
// ----------------------------------------------------------------------------
// aabbsb_sqrt: iterative floor square root
// Digit-by-digit square root producing one result bit per cycle.
// ----------------------------------------------------------------------------
module aabbsb_sqrt
   import aabbsb_pkg::*;
#(
   parameter int W = 24
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [2*W-1:0] radicand,
   output logic           busy,
   output logic [W-1:0]   root
);

   localparam int CW = $clog2(W + 1);

   logic [2*W-1:0] rad_ff, rad_in;
   logic [W+1:0]   rem_ff, rem_in, rem_sh, trial;
   logic [W-1:0]   root_ff, root_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;

   // One step: bring down two radicand bits and try to subtract 4*root+1.
   always_comb begin
      rem_sh  = {rem_ff[W-1:0], rad_ff[2*W-1:2*W-2]};
      trial   = {root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[2*W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

@@ hw/rtl/aabb_and_sphere_bounds_top.sv @@
// ----------------------------------------------------------------------------
// aabb_and_sphere_bounds_top: bounding box and bounding sphere of a mesh
// Three axis lanes track surface and mesh bounds; a merging stage sums the
// squared half extents and takes their square root for the sphere radius.
// ----------------------------------------------------------------------------
// While the sequencer is idle, vertex words stream in one per cycle, and an
// ordinary vertex is taken every cycle. A vertex that ends a surface
// (req_tlast) produces a surface bounds word; one that ends the mesh
// (req_tuser) produces the surface word and then the mesh bounds word, after
// which both trackers start afresh. Each bounds word passes through the
// capture, squaring, start, root and load states, and the shared square-root
// unit yields one radius bit per cycle; req_tready stays low meanwhile. A
// finished word waits in the output register while new vertices are taken.
module aabb_and_sphere_bounds_top
   import aabbsb_pkg::*;
#(
   parameter int  COORD_BITS = 24,
   localparam int IN_W       = ((3 * COORD_BITS + 7) / 8) * 8,
   localparam int OUT_W      = ((7 * COORD_BITS - 3 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [IN_W-1:0]  req_tdata,   // pos_x, pos_y, pos_z, zero pad
   input  logic             req_tlast,   // end_of_surface
   input  logic             req_tuser,   // end_of_mesh
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [OUT_W-1:0] rsp_tdata,   // center_x/y/z, half_x/y/z, radius, pad
   output logic             rsp_tlast,   // last
   output logic             rsp_tuser    // is_mesh_bound
);

   localparam int CB = COORD_BITS;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CAPT  = 3'd1;
   localparam logic [2:0] ST_SQ    = 3'd2;
   localparam logic [2:0] ST_START = 3'd3;
   localparam logic [2:0] ST_ROOT  = 3'd4;
   localparam logic [2:0] ST_LOAD  = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic                 surf_started_ff, surf_started_in;
   logic                 mesh_started_ff, mesh_started_in;
   logic                 sel_mesh_ff, sel_mesh_in;
   logic                 pend_mesh_ff, pend_mesh_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [OUT_W-1:0]     rsp_tdata_ff, rsp_tdata_in;
   logic                 rsp_tlast_ff, rsp_tlast_in;
   logic                 rsp_tuser_ff, rsp_tuser_in;

   logic                 accept, surf_end;
   lane_ctrl_type        lane_ctrl;
   logic signed [CB-1:0] pos_w [3];
   logic signed [CB-1:0] centre_w [3];
   logic [CB-2:0]        half_w [3];
   logic [2*CB-3:0]      square_w [3];
   logic [2*CB-1:0]      sum_sq;
   logic                 sq_busy;
   logic [CB-1:0]        root_w;

   assign accept   = req_tvalid && req_tready;
   assign surf_end = req_tlast || req_tuser;

   // Control word shared by the three lanes.
   always_comb begin
      lane_ctrl.take         = accept;
      lane_ctrl.surf_end     = surf_end;
      lane_ctrl.surf_started = surf_started_ff;
      lane_ctrl.mesh_started = mesh_started_ff;
      lane_ctrl.sel_mesh     = sel_mesh_ff;
      lane_ctrl.capture      = (state_ff == ST_CAPT);
      lane_ctrl.square       = (state_ff == ST_SQ);
   end

   // One lane per axis.
   for (genvar a = 0; a < 3; a++) begin : g_lane
      assign pos_w[a] = $signed(req_tdata[a*CB +: CB]);
      aabbsb_lane #(.CB(CB)) u_lane (
         .clock  (clock),
         .ctrl   (lane_ctrl),
         .pos    (pos_w[a]),
         .centre (centre_w[a]),
         .half   (half_w[a]),
         .square (square_w[a])
      );
   end

   // Merging stage: sum of squared half extents feeds the square root.
   assign sum_sq = (2*CB)'(square_w[0]) + (2*CB)'(square_w[1]) +
                   (2*CB)'(square_w[2]);

   aabbsb_sqrt #(.W(CB)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_START),
      .radicand (sum_sq),
      .busy     (sq_busy),
      .root     (root_w)
   );

   assign req_tready = (state_ff == ST_IDLE);

   // Sequencer and output register.
   always_comb begin
      state_in        = state_ff;
      surf_started_in = surf_started_ff;
      mesh_started_in = mesh_started_ff;
      sel_mesh_in     = sel_mesh_ff;
      pend_mesh_in    = pend_mesh_ff;
      rsp_tvalid_in   = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in    = rsp_tdata_ff;
      rsp_tlast_in    = rsp_tlast_ff;
      rsp_tuser_in    = rsp_tuser_ff;
      if (accept) begin
         surf_started_in = !surf_end;
         if (surf_end) begin
            mesh_started_in = !req_tuser;
            pend_mesh_in    = req_tuser;
            sel_mesh_in     = 1'b0;
            state_in        = ST_CAPT;
         end
      end
      case (state_ff)
         ST_IDLE: begin
         end
         ST_CAPT: begin
            state_in = ST_SQ;
         end
         ST_SQ: begin
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (!sq_busy) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = OUT_W'({root_w, half_w[2], half_w[1], half_w[0],
                                       centre_w[2], centre_w[1], centre_w[0]});
               rsp_tuser_in  = sel_mesh_ff;
               rsp_tlast_in  = sel_mesh_ff || !pend_mesh_ff;
               if (pend_mesh_ff && !sel_mesh_ff) begin
                  sel_mesh_in = 1'b1;
                  state_in    = ST_CAPT;
               end else begin
                  sel_mesh_in  = 1'b0;
                  pend_mesh_in = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
      rsp_tuser_ff <= rsp_tuser_in;
      if (reset) begin
         state_ff        <= ST_IDLE;
         surf_started_ff <= 1'b0;
         mesh_started_ff <= 1'b0;
         sel_mesh_ff     <= 1'b0;
         pend_mesh_ff    <= 1'b0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         surf_started_ff <= surf_started_in;
         mesh_started_ff <= mesh_started_in;
         sel_mesh_ff     <= sel_mesh_in;
         pend_mesh_ff    <= pend_mesh_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef SYNTHESIS
   // A surface end always starts a bounds computation.
   a_surf_end_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && surf_end) |=> (state_ff == ST_CAPT))
      else $error("surface end did not start a bounds computation");

   // Mesh bounds are always the final word for their vertex.
   a_mesh_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("mesh bounds word without last");

   // The root unit is idle whenever vertices are being taken.
   a_root_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !sq_busy)
      else $error("square root busy while idle");

   // Finishing the root moves the sequencer to the output load.
   a_root_to_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT && !sq_busy) |=> (state_ff == ST_LOAD))
      else $error("sequencer missed the end of the square root");
`endif

endmodule
